// File: design/cbc_pkg.sv
package cbc_pkg;

    // Field widths of the accumulators and of the result.
    localparam int SUM_W = 22;
    localparam int CNT_W = 15;
    localparam int DCNT_W = 5;
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // Configuration port.
    localparam int APB_AW = 5;
    localparam int APB_DW = 32;
    localparam logic [2:0] REG_ROI_ROW_START = 3'd0;
    localparam logic [2:0] REG_ROW_STEP = 3'd1;
    localparam logic [2:0] REG_COL_STEP = 3'd2;
    localparam logic [2:0] REG_RED_MIN_CNT = 3'd3;
    localparam logic [2:0] REG_GREEN_MIN_CNT = 3'd4;

    localparam logic [6:0] RST_ROI_ROW_START = 7'd30;
    localparam logic [3:0] RST_ROW_STEP = 4'd2;
    localparam logic [3:0] RST_COL_STEP = 4'd2;
    localparam logic [14:0] RST_RED_MIN_CNT = 15'd35;
    localparam logic [14:0] RST_GREEN_MIN_CNT = 15'd35;

    // Reported colour codes.
    localparam logic [1:0] COLOR_NONE = 2'd0;
    localparam logic [1:0] COLOR_RED = 2'd1;
    localparam logic [1:0] COLOR_GREEN = 2'd2;

    // Fixed classification thresholds on the 8-bit channels.
    localparam logic [7:0] RED_R_MIN = 8'd100;
    localparam logic [7:0] RED_GB_MAX = 8'd90;
    localparam logic [7:0] GREEN_G_MIN = 8'd95;
    localparam logic [7:0] GREEN_RB_MAX = 8'd120;

    typedef struct packed {
        logic [15:0] pixel;
        logic        end_of_frame;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  color;
        logic [7:0]  centroid_col;
        logic [14:0] pixel_count;
    } t_out_item;

endpackage

// File: design/color_blob_centroid_unit.sv
// A pixel that is not the end of frame is absorbed at full rate while ready is high.
// An end-of-frame pixel passes through the decision, the divider and the output load before
// its result shows, skipping the divider when no colour wins; ready is low until it is loaded.
// A write to the start row or either step re-aligns the sampling phases on the same divider,
// holding ready low from the write until the re-alignment has finished.
// Reset is synchronous and active low: registers take their defaults, counters and sums clear.
module color_blob_centroid_unit #(
    parameter int FRAME_WIDTH = 160,
    parameter int FRAME_HEIGHT = 120
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  cbc_pkg::t_in_item        i_data,
    output logic                     o_valid,
    input  logic                     i_ready,
    output cbc_pkg::t_out_item       o_data,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [cbc_pkg::APB_AW-1:0] paddr,
    input  logic [cbc_pkg::APB_DW-1:0] pwdata,
    output logic [cbc_pkg::APB_DW-1:0] prdata,
    output logic                     pready
);
    import cbc_pkg::*;

    localparam int CW = (FRAME_WIDTH > 2) ? $clog2(FRAME_WIDTH) : 1;
    localparam int RW = $clog2(FRAME_HEIGHT + 1);
    localparam logic [CW-1:0] COL_LAST = CW'(FRAME_WIDTH - 1);
    localparam logic [RW-1:0] ROW_END = RW'(FRAME_HEIGHT);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DEC  = 4'b0010,
        S_DIV  = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    typedef enum logic [1:0] {
        JOB_CENT = 2'd0,
        JOB_COL  = 2'd1,
        JOB_ROW  = 2'd2
    } t_job;

    // Configuration registers.
    logic [6:0]  r_roi;
    logic [3:0]  r_row_step;
    logic [3:0]  r_col_step;
    logic [14:0] r_red_min;
    logic [14:0] r_green_min;

    // Sequencer, position and accumulators.
    t_state r_state, n_state;
    t_job   r_job, n_job;
    logic   r_sync, n_sync;
    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic [3:0] r_cp, n_cp;
    logic [3:0] r_rp, n_rp;
    logic [SUM_W-1:0] r_rsum, n_rsum, r_gsum, n_gsum;
    logic [CNT_W-1:0] r_rtot, n_rtot, r_gtot, n_gtot;

    // Shared restoring divider.
    logic [CNT_W-1:0]  r_rem, n_rem;
    logic [SUM_W-1:0]  r_quo, n_quo;
    logic [CNT_W-1:0]  r_dvs, n_dvs;
    logic [DCNT_W-1:0] r_dcnt, n_dcnt;

    // Result holding.
    logic        r_ovalid, n_ovalid;
    t_out_item   r_odata, n_odata;
    logic [1:0]  r_ocolor, n_ocolor;
    logic [14:0] r_ocount, n_ocount;

    logic       cfg_wr;
    logic [2:0] cfg_idx;
    logic       cfg_wr_phase;
    logic [3:0] rs, cs;
    logic       in_xfer;
    logic       row_in_roi;
    logic       sample;
    logic [7:0] ch_r, ch_g, ch_b;
    logic       is_red, is_green;
    logic [SUM_W:0] rsum_add, gsum_add;
    logic [CNT_W:0] div_shift;
    logic [CNT_W+1:0] div_diff;
    logic [SUM_W-1:0] row_diff;
    logic [RW-1:0] row_inc;
    logic       red_win, green_win;

    // Configuration port decode and read-back.
    assign pready = 1'b1;
    assign cfg_idx = paddr[APB_AW-1:2];
    assign cfg_wr = psel && penable && pwrite;
    assign cfg_wr_phase = cfg_wr && (cfg_idx == REG_ROI_ROW_START ||
                                     cfg_idx == REG_ROW_STEP ||
                                     cfg_idx == REG_COL_STEP);

    always_comb begin
        case (cfg_idx)
            REG_ROI_ROW_START:  prdata = APB_DW'(r_roi);
            REG_ROW_STEP:       prdata = APB_DW'(r_row_step);
            REG_COL_STEP:       prdata = APB_DW'(r_col_step);
            REG_RED_MIN_CNT:    prdata = APB_DW'(r_red_min);
            REG_GREEN_MIN_CNT:  prdata = APB_DW'(r_green_min);
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_roi       <= RST_ROI_ROW_START;
            r_row_step  <= RST_ROW_STEP;
            r_col_step  <= RST_COL_STEP;
            r_red_min   <= RST_RED_MIN_CNT;
            r_green_min <= RST_GREEN_MIN_CNT;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_ROI_ROW_START:  r_roi       <= pwdata[6:0];
                REG_ROW_STEP:       r_row_step  <= pwdata[3:0];
                REG_COL_STEP:       r_col_step  <= pwdata[3:0];
                REG_RED_MIN_CNT:    r_red_min   <= pwdata[14:0];
                REG_GREEN_MIN_CNT:  r_green_min <= pwdata[14:0];
                default: begin
                end
            endcase
        end
    end

    // A step of zero behaves as a step of one.
    assign rs = (r_row_step == 4'd0) ? 4'd1 : r_row_step;
    assign cs = (r_col_step == 4'd0) ? 4'd1 : r_col_step;

    // The input is taken only when idle with the sampling phases aligned.
    assign o_ready = (r_state == S_IDLE) && !r_sync && !cfg_wr_phase;
    assign in_xfer = i_valid && o_ready;

    // Sampling decision from the row and column phase counters.
    assign row_in_roi = (SUM_W'(r_row) >= SUM_W'(r_roi));
    assign sample = (r_row < ROW_END) && row_in_roi && (r_rp == 4'd0) && (r_cp == 4'd0);

    // Colour classification on the expanded channels.
    assign ch_r = {i_data.pixel[15:11], 3'b000};
    assign ch_g = {i_data.pixel[10:5], 2'b00};
    assign ch_b = {i_data.pixel[4:0], 3'b000};
    assign is_red = (ch_r > RED_R_MIN) && (ch_g < RED_GB_MAX) && (ch_b < RED_GB_MAX) &&
                    ({2'b00, ch_r, 1'b0} > (11'(ch_g) * 11'd3)) &&
                    ({2'b00, ch_r, 1'b0} > (11'(ch_b) * 11'd3));
    assign is_green = (ch_g > GREEN_G_MIN) && (ch_r < GREEN_RB_MAX) &&
                      (ch_b < GREEN_RB_MAX) &&
                      ((11'(ch_g) * 11'd4) > (11'(ch_r) * 11'd5)) &&
                      ((13'(ch_g) * 13'd20) > (13'(ch_b) * 13'd23));

    assign rsum_add = {1'b0, r_rsum} + (SUM_W+1)'(r_col);
    assign gsum_add = {1'b0, r_gsum} + (SUM_W+1)'(r_col);

    // One restoring division step: shift in a dividend bit and try the subtraction.
    assign div_shift = {r_rem, r_quo[SUM_W-1]};
    assign div_diff = {1'b0, div_shift} - {2'b00, r_dvs};

    assign row_diff = SUM_W'(r_row) - SUM_W'(r_roi);
    assign row_inc = r_row + 1'b1;

    assign red_win = (r_rtot > r_red_min) && (r_rtot >= r_gtot);
    assign green_win = (r_gtot > r_green_min);

    // Sequencer and datapath next state.
    always_comb begin
        n_state  = r_state;
        n_job    = r_job;
        n_sync   = r_sync;
        n_col    = r_col;
        n_row    = r_row;
        n_cp     = r_cp;
        n_rp     = r_rp;
        n_rsum   = r_rsum;
        n_gsum   = r_gsum;
        n_rtot   = r_rtot;
        n_gtot   = r_gtot;
        n_rem    = r_rem;
        n_quo    = r_quo;
        n_dvs    = r_dvs;
        n_dcnt   = r_dcnt;
        n_ovalid = r_ovalid;
        n_odata  = r_odata;
        n_ocolor = r_ocolor;
        n_ocount = r_ocount;

        // The output register empties on its own transfer.
        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (r_sync && !cfg_wr_phase) begin
                    // Re-align the column phase: column modulo column step.
                    n_quo   = SUM_W'(r_col);
                    n_rem   = '0;
                    n_dvs   = CNT_W'(cs);
                    n_dcnt  = DCNT_W'(SUM_W);
                    n_job   = JOB_COL;
                    n_state = S_DIV;
                end else if (in_xfer) begin
                    // Accumulate a sampled pixel of either colour.
                    if (sample && is_red) begin
                        n_rsum = rsum_add[SUM_W] ? SUM_MAX : rsum_add[SUM_W-1:0];
                        if (r_rtot != CNT_MAX) begin
                            n_rtot = r_rtot + 1'b1;
                        end
                    end
                    if (sample && is_green) begin
                        n_gsum = gsum_add[SUM_W] ? SUM_MAX : gsum_add[SUM_W-1:0];
                        if (r_gtot != CNT_MAX) begin
                            n_gtot = r_gtot + 1'b1;
                        end
                    end
                    // Advance the raster position; it freezes past the last row.
                    if (r_row < ROW_END) begin
                        if (r_col == COL_LAST) begin
                            n_col = '0;
                            n_cp  = 4'd0;
                            n_row = row_inc;
                            if (SUM_W'(row_inc) <= SUM_W'(r_roi)) begin
                                n_rp = 4'd0;
                            end else if (r_rp + 1'b1 >= rs) begin
                                n_rp = 4'd0;
                            end else begin
                                n_rp = r_rp + 1'b1;
                            end
                        end else begin
                            n_col = r_col + 1'b1;
                            n_cp  = (r_cp + 1'b1 >= cs) ? 4'd0 : r_cp + 1'b1;
                        end
                    end
                    if (i_data.end_of_frame) begin
                        n_col   = '0;
                        n_row   = '0;
                        n_cp    = 4'd0;
                        n_rp    = 4'd0;
                        n_state = S_DEC;
                    end
                end
            end
            S_DEC: begin
                // Pick the winner and start the centroid division; clear the frame.
                n_rem  = '0;
                n_dcnt = DCNT_W'(SUM_W);
                n_job  = JOB_CENT;
                if (red_win) begin
                    n_ocolor = COLOR_RED;
                    n_ocount = r_rtot;
                    n_quo    = r_rsum;
                    n_dvs    = r_rtot;
                    n_state  = S_DIV;
                end else if (green_win) begin
                    n_ocolor = COLOR_GREEN;
                    n_ocount = r_gtot;
                    n_quo    = r_gsum;
                    n_dvs    = r_gtot;
                    n_state  = S_DIV;
                end else begin
                    n_ocolor = COLOR_NONE;
                    n_ocount = '0;
                    n_quo    = '0;
                    n_state  = S_OUT;
                end
                n_rsum = '0;
                n_gsum = '0;
                n_rtot = '0;
                n_gtot = '0;
            end
            S_DIV: begin
                if (r_dcnt != '0) begin
                    if (!div_diff[CNT_W+1]) begin
                        n_rem = div_diff[CNT_W-1:0];
                        n_quo = {r_quo[SUM_W-2:0], 1'b1};
                    end else begin
                        n_rem = div_shift[CNT_W-1:0];
                        n_quo = {r_quo[SUM_W-2:0], 1'b0};
                    end
                    n_dcnt = r_dcnt - 1'b1;
                end else begin
                    case (r_job)
                        JOB_CENT: begin
                            n_state = S_OUT;
                        end
                        JOB_COL: begin
                            n_cp = r_rem[3:0];
                            if (row_in_roi) begin
                                // Row phase: distance from the start row modulo row step.
                                n_quo  = row_diff;
                                n_rem  = '0;
                                n_dvs  = CNT_W'(rs);
                                n_dcnt = DCNT_W'(SUM_W);
                                n_job  = JOB_ROW;
                            end else begin
                                n_rp    = 4'd0;
                                n_sync  = 1'b0;
                                n_state = S_IDLE;
                            end
                        end
                        JOB_ROW: begin
                            n_rp    = r_rem[3:0];
                            n_sync  = 1'b0;
                            n_state = S_IDLE;
                        end
                        default: begin
                            n_sync  = 1'b0;
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_OUT: begin
                // Load the result once the output register is free.
                if (!r_ovalid || i_ready) begin
                    n_ovalid             = 1'b1;
                    n_odata.color        = r_ocolor;
                    n_odata.pixel_count  = r_ocount;
                    n_odata.centroid_col = (r_quo > SUM_W'(255)) ? 8'hFF : r_quo[7:0];
                    n_state              = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // A write to the start row or a step forces a phase re-alignment.
        if (cfg_wr_phase) begin
            n_sync = 1'b1;
        end
    end

    // Control state and accumulators.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_job    <= JOB_CENT;
            r_sync   <= 1'b0;
            r_col    <= '0;
            r_row    <= '0;
            r_cp     <= 4'd0;
            r_rp     <= 4'd0;
            r_rsum   <= '0;
            r_gsum   <= '0;
            r_rtot   <= '0;
            r_gtot   <= '0;
            r_dcnt   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_job    <= n_job;
            r_sync   <= n_sync;
            r_col    <= n_col;
            r_row    <= n_row;
            r_cp     <= n_cp;
            r_rp     <= n_rp;
            r_rsum   <= n_rsum;
            r_gsum   <= n_gsum;
            r_rtot   <= n_rtot;
            r_gtot   <= n_gtot;
            r_dcnt   <= n_dcnt;
            r_ovalid <= n_ovalid;
        end
    end

    // Divider and result payload.
    always_ff @(posedge i_clk) begin
        r_rem    <= n_rem;
        r_quo    <= n_quo;
        r_dvs    <= n_dvs;
        r_odata  <= n_odata;
        r_ocolor <= n_ocolor;
        r_ocount <= n_ocount;
    end

    assign o_valid = r_ovalid;
    assign o_data = r_odata;

endmodule

// File: design/cbc_checker.sv
module cbc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_ready,
    input cbc_pkg::t_in_item  i_data,
    input logic               o_valid,
    input logic               i_ready,
    input cbc_pkg::t_out_item o_data
);
    import cbc_pkg::*;

    // A stalled result holds its value until its transfer.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result changed while stalled");

    // A result never carries an undefined colour code.
    a_color_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.color == COLOR_NONE || o_data.color == COLOR_RED ||
                     o_data.color == COLOR_GREEN))
        else $error("undefined colour code");

    // No blob found means zero centroid and zero count.
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.color == COLOR_NONE |->
            o_data.centroid_col == 8'd0 && o_data.pixel_count == 15'd0)
        else $error("empty result with non-zero fields");

    // A reported blob has at least one pixel.
    a_blob_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.color != COLOR_NONE |-> o_data.pixel_count != 15'd0)
        else $error("reported blob with zero count");

    // The end-of-frame transfer stops intake while the result is worked out.
    a_eof_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_data.end_of_frame |=> !o_ready)
        else $error("input taken during end-of-frame processing");

endmodule

bind color_blob_centroid_unit cbc_checker u_cbc_checker (.*);

// File: test/color_blob_centroid_checker.sv
module color_blob_centroid_checker #(
    parameter int FRAME_WIDTH = 160,
    parameter int FRAME_HEIGHT = 120
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_ready,
    input  cbc_pkg::t_in_item            i_in_data,
    input  logic                         i_out_valid,
    input  logic                         i_out_ready,
    input  cbc_pkg::t_out_item           i_out_data,
    input  logic                         i_psel,
    input  logic                         i_penable,
    input  logic                         i_pwrite,
    input  logic                         i_pready,
    input  logic [cbc_pkg::APB_AW-1:0]   i_paddr,
    input  logic [cbc_pkg::APB_DW-1:0]   i_pwdata,
    output int unsigned                  o_mismatches,
    output int unsigned                  o_pending,
    output int unsigned                  o_reports
);
    import cbc_pkg::*;

    // Shadow copies of the configuration registers.
    logic [6:0]       roi_row_start;
    logic [3:0]       row_step;
    logic [3:0]       col_step;
    logic [CNT_W-1:0] red_min_cnt;
    logic [CNT_W-1:0] green_min_cnt;

    // Raster position and per-colour accumulators of the frame in progress.
    logic [7:0]       col_pos;
    logic [6:0]       row_pos;
    logic [SUM_W-1:0] red_col_sum;
    logic [SUM_W-1:0] green_col_sum;
    logic [CNT_W-1:0] red_total;
    logic [CNT_W-1:0] green_total;

    // Blob reports predicted but not yet seen on the output.
    t_out_item blob_report_q[$];

    task automatic clear_frame();
        col_pos = '0;
        row_pos = '0;
        red_col_sum = '0;
        green_col_sum = '0;
        red_total = '0;
        green_total = '0;
    endtask

    // Adds one pixel to a colour, saturating both the sum and the count.
    task automatic add_to_blob(inout logic [SUM_W-1:0] col_sum,
                               inout logic [CNT_W-1:0] total,
                               input int unsigned col);
        int unsigned grown;
        grown = col_sum + col;
        col_sum = (grown > SUM_MAX) ? SUM_MAX : grown[SUM_W-1:0];
        if (total < CNT_MAX) begin
            total = total + 1'b1;
        end
    endtask

    // Classifies one pixel, advances the raster position and, at the end of
    // a frame, queues the report that the block should give.
    task automatic predict_blob_pixel(input t_in_item item);
        int unsigned r, g, b, rs, cs, rp, cp, start, quot;
        bit          sampled, is_red, is_green;
        t_out_item   report;
        rs = (row_step == 0) ? 1 : row_step;
        cs = (col_step == 0) ? 1 : col_step;
        rp = row_pos;
        cp = col_pos;
        start = roi_row_start;
        sampled = (rp < FRAME_HEIGHT) && (cp < FRAME_WIDTH) && (rp >= start) &&
                  (((rp - start) % rs) == 0) && ((cp % cs) == 0);
        if (sampled) begin
            r = {item.pixel[15:11], 3'b000};
            g = {item.pixel[10:5], 2'b00};
            b = {item.pixel[4:0], 3'b000};
            is_red = (r > 100) && (g < 90) && (b < 90) && (2 * r > 3 * g) && (2 * r > 3 * b);
            is_green = (g > 95) && (r < 120) && (b < 120) && (4 * g > 5 * r) &&
                       (20 * g > 23 * b);
            if (is_red) begin
                add_to_blob(red_col_sum, red_total, cp);
            end
            if (is_green) begin
                add_to_blob(green_col_sum, green_total, cp);
            end
        end

        // The position freezes once the last row has been passed.
        if (rp < FRAME_HEIGHT) begin
            cp = cp + 1;
            if (cp >= FRAME_WIDTH) begin
                cp = 0;
                rp = rp + 1;
            end
            col_pos = cp[7:0];
            row_pos = rp[6:0];
        end

        if (item.end_of_frame) begin
            report.color = COLOR_NONE;
            report.pixel_count = '0;
            quot = 0;
            if (red_total > red_min_cnt && red_total >= green_total) begin
                report.color = COLOR_RED;
                report.pixel_count = red_total;
                quot = red_col_sum / red_total;
            end else if (green_total > green_min_cnt) begin
                report.color = COLOR_GREEN;
                report.pixel_count = green_total;
                quot = green_col_sum / green_total;
            end
            report.centroid_col = (quot > 255) ? 8'd255 : quot[7:0];
            blob_report_q.push_back(report);
            clear_frame();
        end
    endtask

    // Watch the register port and both channels on every rising edge.
    always @(posedge i_clk) begin : monitor
        t_out_item want;
        if (!i_rst_n) begin
            roi_row_start = RST_ROI_ROW_START;
            row_step = RST_ROW_STEP;
            col_step = RST_COL_STEP;
            red_min_cnt = RST_RED_MIN_CNT;
            green_min_cnt = RST_GREEN_MIN_CNT;
            clear_frame();
            blob_report_q.delete();
            o_mismatches = 0;
            o_reports = 0;
        end else begin
            // A register write lands when the access phase completes.
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[4:2])
                    REG_ROI_ROW_START:  roi_row_start = i_pwdata[6:0];
                    REG_ROW_STEP:       row_step = i_pwdata[3:0];
                    REG_COL_STEP:       col_step = i_pwdata[3:0];
                    REG_RED_MIN_CNT:    red_min_cnt = i_pwdata[CNT_W-1:0];
                    REG_GREEN_MIN_CNT:  green_min_cnt = i_pwdata[CNT_W-1:0];
                    default: ;
                endcase
            end

            // Each output transfer is matched against the oldest prediction.
            if (i_out_valid && i_out_ready) begin
                o_reports++;
                if (blob_report_q.size() == 0) begin
                    $error("unexpected blob report: color %0d centroid_col %0d pixel_count %0d",
                           i_out_data.color, i_out_data.centroid_col,
                           i_out_data.pixel_count);
                    o_mismatches++;
                end else begin
                    want = blob_report_q.pop_front();
                    if (i_out_data.color !== want.color) begin
                        $error("color: expected %0d, got %0d", want.color, i_out_data.color);
                        o_mismatches++;
                    end
                    if (i_out_data.centroid_col !== want.centroid_col) begin
                        $error("centroid_col: expected %0d, got %0d",
                               want.centroid_col, i_out_data.centroid_col);
                        o_mismatches++;
                    end
                    if (i_out_data.pixel_count !== want.pixel_count) begin
                        $error("pixel_count: expected %0d, got %0d",
                               want.pixel_count, i_out_data.pixel_count);
                        o_mismatches++;
                    end
                end
            end

            if (i_in_valid && i_in_ready) begin
                predict_blob_pixel(i_in_data);
            end
        end
        o_pending = blob_report_q.size();
    end

endmodule

// File: test/color_blob_centroid_unit_test.sv
module color_blob_centroid_unit_test;
    import cbc_pkg::*;

    localparam int IDLE_PCT = 18;
    localparam int SETTLE_CYCLES = 50;
    localparam int TAIL_CYCLES = 60;
    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_PHASES = 6;
    localparam int FRAMES_PER_PHASE = 3;
    localparam int RANDOM_PIXELS = 440;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_ready;
    t_in_item              i_data;
    logic                  o_valid;
    logic                  i_ready;
    t_out_item             o_data;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_AW-1:0]     paddr;
    logic [APB_DW-1:0]     pwdata;
    logic [APB_DW-1:0]     prdata;
    logic                  pready;

    int unsigned mismatches;
    int unsigned pending;
    int unsigned reports;
    int unsigned pixels_sent;
    int unsigned frames_sent;
    int unsigned settings_used;
    bit          calm;
    bit          hold_req;
    bit          hold_done;

    always #2 i_clk = ~i_clk;

    color_blob_centroid_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    color_blob_centroid_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_in_data    (i_data),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_out_data   (o_data),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_reports    (reports)
    );

    // Picks a pixel: mostly clear red or green, some near the thresholds, some anything.
    function automatic logic [15:0] pick_pixel(input int red_pct, input int green_pct);
        int sel;
        sel = $urandom_range(99);
        if (sel < red_pct) begin
            return {5'($urandom_range(31, 16)), 6'($urandom_range(21, 0)),
                    5'($urandom_range(10, 0))};
        end else if (sel < red_pct + green_pct) begin
            return {5'($urandom_range(11, 0)), 6'($urandom_range(63, 30)),
                    5'($urandom_range(12, 0))};
        end else if ($urandom_range(1) == 0) begin
            return {5'($urandom_range(16, 11)), 6'($urandom_range(32, 20)),
                    5'($urandom_range(16, 9))};
        end
        return 16'($urandom);
    endfunction

    // Offers one pixel, with a random idle gap first, and waits for its transfer.
    task automatic send_pixel(input logic [15:0] px, input bit eof);
        t_in_item item;
        bit       taken;
        item.pixel = px;
        item.end_of_frame = eof;
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= item;
        do begin
            @(negedge i_clk);
            taken = o_ready;
            @(posedge i_clk);
        end while (!taken);
        pixels_sent++;
        if (eof) begin
            frames_sent++;
        end
    endtask

    task automatic send_frame(input int len, input int red_pct, input int green_pct);
        for (int i = 0; i < len; i++) begin
            send_pixel(pick_pixel(red_pct, green_pct), i == len - 1);
        end
    endtask

    // Stops offering pixels and waits until every predicted report has arrived.
    task automatic wait_idle();
        i_valid <= 1'b0;
        do begin
            @(negedge i_clk);
        end while (pending != 0);
        @(posedge i_clk);
    endtask

    // One register write; the bits above the field are filled with noise.
    task automatic apb_write(input logic [2:0] idx, input int width, input int unsigned value);
        logic [APB_DW-1:0] mask;
        logic [APB_DW-1:0] data;
        bit                done;
        mask = {APB_DW{1'b1}} >> (APB_DW - width);
        data = ($urandom & ~mask) | (value & mask);
        // Let any re-alignment from the previous write finish first.
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(negedge i_clk);
            done = pready;
            @(posedge i_clk);
        end while (!done);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic configure(input int unsigned roi, input int unsigned rs, input int unsigned cs,
                             input int unsigned rmin, input int unsigned gmin);
        wait_idle();
        apb_write(REG_ROI_ROW_START, 7, roi);
        apb_write(REG_ROW_STEP, 4, rs);
        apb_write(REG_COL_STEP, 4, cs);
        apb_write(REG_RED_MIN_CNT, CNT_W, rmin);
        apb_write(REG_GREEN_MIN_CNT, CNT_W, gmin);
        settings_used++;
    endtask

    // Result side: random stalls, one long hold-off when asked.
    initial begin
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end else begin
                i_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Ends the run when nothing has moved for too long.
    initial begin : watchdog
        int unsigned stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready) || (psel && penable)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
        end
        $display("Verification failed");
        $finish;
    end

    // Stimulus and verdict.
    initial begin : stimulus
        int unsigned roi, rs, cs, rmin, gmin, len, red_pct, green_pct, phase, random_start;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_data <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        pixels_sent = 0;
        frames_sent = 0;
        settings_used = 0;
        calm = 1'b0;
        hold_req = 1'b0;
        hold_done = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Every pixel sampled, any blob at all reported.
        configure(0, 1, 1, 0, 0);
        send_pixel(16'h0000, 1'b0);    // black
        send_pixel(16'hFFFF, 1'b0);    // white
        send_pixel(16'hF800, 1'b0);    // pure red
        send_pixel(16'h07E0, 1'b0);    // pure green
        send_pixel(16'h001F, 1'b0);    // pure blue
        send_pixel(16'h6800, 1'b0);    // red channel just over its floor
        send_pixel(16'h6000, 1'b0);    // red channel just under its floor
        send_pixel(16'h0300, 1'b0);    // green channel just over its floor
        send_pixel(16'h02E0, 1'b0);    // green channel just under its floor
        send_pixel(16'h8AC0, 1'b0);    // red to green ratio just passing
        send_pixel(16'h82C0, 1'b0);    // red to green ratio just failing
        send_pixel(16'h5320, 1'b0);    // green to red ratio exactly on the limit
        send_pixel(16'h032B, 1'b1);    // green to blue ratio just failing
        send_pixel(16'hF800, 1'b1);    // lone red pixel
        send_pixel(16'h07E0, 1'b1);    // lone green pixel
        send_pixel(16'hF800, 1'b0);    // equal counts: red wins
        send_pixel(16'h07E0, 1'b1);
        send_pixel(16'h0000, 1'b1);    // nothing found

        // Both steps zero, which must behave as a step of one.
        configure(0, 0, 0, 1, CNT_MAX);
        send_pixel(16'hF800, 1'b0);
        send_pixel(16'hF800, 1'b0);
        send_pixel(16'h07E0, 1'b1);

        // Random phases; the first few pin the register extremes.
        random_start = pixels_sent;
        phase = 0;
        while (phase < RANDOM_PHASES || pixels_sent - random_start < RANDOM_PIXELS) begin
            case (phase)
                0: begin
                    roi = 119; rs = 1; cs = 1; rmin = 0; gmin = 0;
                end
                1: begin
                    roi = 127; rs = 15; cs = 15; rmin = CNT_MAX; gmin = CNT_MAX;
                end
                2: begin
                    roi = 0; rs = 8; cs = 8; rmin = 19200; gmin = 0;
                end
                3: begin
                    roi = 0; rs = 0; cs = 0; rmin = 0; gmin = 19200;
                end
                default: begin
                    len = $urandom_range(99);
                    roi = (len < 60) ? $urandom_range(2) :
                          (len < 85) ? $urandom_range(119) : $urandom_range(127);
                    rs = ($urandom_range(99) < 80) ? $urandom_range(8, 1) : $urandom_range(15);
                    cs = ($urandom_range(99) < 80) ? $urandom_range(8, 1) : $urandom_range(15);
                    rmin = ($urandom_range(99) < 70) ? $urandom_range(6) : $urandom_range(CNT_MAX);
                    gmin = ($urandom_range(99) < 70) ? $urandom_range(6) : $urandom_range(CNT_MAX);
                end
            endcase
            configure(roi, rs, cs, rmin, gmin);
            calm = (phase == 4);
            hold_req = (phase == 5);
            for (int f = 0; f < FRAMES_PER_PHASE; f++) begin
                len = $urandom_range(12, 1);
                // A frame that wraps into the next rows, and short frames under back-pressure.
                if ((phase == 3 || phase == 4) && f == 0) begin
                    len = $urandom_range(200, 161);
                end
                if (phase == 5) begin
                    len = $urandom_range(6, 1);
                end
                red_pct = $urandom_range(60);
                green_pct = $urandom_range(80 - red_pct);
                send_frame(len, red_pct, green_pct);
            end
            phase++;
        end
        calm = 1'b0;

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Checked %0d blob reports from %0d frames and %0d pixels under %0d settings.",
                 reports, frames_sent, pixels_sent, settings_used);
        $display("Settings included zero steps, a start row past the frame and a long stall.");
        if (mismatches == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
